// ===== rtl/mbce_pkg.sv =====
// mbce_pkg: shared types and constants for the mono bitmap color expander.
// No dependencies; used by the interfaces, config registers and top level.
package mbce_pkg;

	localparam int PIX_PER_BYTE = 8;
	localparam int BYTE_W       = 8;
	localparam int COLOR_W      = 16;
	localparam int SIZE_W       = 10;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = COLOR_W;
	localparam int MAX_SIDE_DEF = 512;

	localparam logic [COLOR_W-1:0] FG_RST     = 16'hFFFF;
	localparam logic [COLOR_W-1:0] BG_RST     = 16'h0000;
	localparam logic [SIZE_W-1:0]  WIDTH_RST  = 10'd8;
	localparam logic [SIZE_W-1:0]  HEIGHT_RST = 10'd8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FG_COLOR    = 2'd0,
		REG_BG_COLOR    = 2'd1,
		REG_AREA_WIDTH  = 2'd2,
		REG_AREA_HEIGHT = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [COLOR_W-1:0] fg_color;
		logic [COLOR_W-1:0] bg_color;
		logic [SIZE_W-1:0]  area_width;
		logic [SIZE_W-1:0]  area_height;
	} cfg_t;

endpackage

// ===== rtl/mbce_if.sv =====
// mbce_if: valid/ready channels of the expander (bitmap bytes in, pixels out).
// Depends on mbce_pkg for field widths.
interface mbce_byte_if;
	logic                         valid;
	logic                         ready;
	logic [mbce_pkg::BYTE_W-1:0]  bitmap_byte;

	modport source (output valid, output bitmap_byte, input ready);
	modport sink   (input valid, input bitmap_byte, output ready);
endinterface

interface mbce_pixel_if;
	logic                         valid;
	logic                         ready;
	logic [mbce_pkg::COLOR_W-1:0] pixel_color;
	logic                         row_end;
	logic                         frame_end;
	logic                         byte_done;

	modport source (output valid, output pixel_color, output row_end, output frame_end,
		output byte_done, input ready);
	modport sink   (input valid, input pixel_color, input row_end, input frame_end,
		input byte_done, output ready);
endinterface

// ===== rtl/mono_bitmap_color_expander.sv =====
// mono_bitmap_color_expander: 1bpp bitmap bytes to RGB565 pixels with row/frame marks.
// Depends on mbce_pkg, mbce_if (channels) and mbce_cfg_regs.
//
//  channel  dir  payload                                       role
//  bitmap   in   bitmap_byte[7:0]                              packed pixels, MSB first
//  pixel    out  pixel_color[15:0] row_end frame_end byte_done one pixel per request
//  cfg      in   cfg_we cfg_idx[1:0] cfg_data[15:0]            register writes
//
// Unless stalled, one pixel leaves per cycle from a registered output stage; a byte
// yields 8 pixels, fewer when the frame ends inside it (trailing bits are dropped).
// The next byte is taken in the cycle its predecessor's last pixel is produced,
// so bytes stream with no gap. Output stalls hold the byte and counters in place.
// Reset clears counters, channel state and registers to their defaults.
module mono_bitmap_color_expander #(
	parameter int MAX_SIDE = mbce_pkg::MAX_SIDE_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	mbce_byte_if.sink                       bitmap,
	mbce_pixel_if.source                    pixel,
	input  logic                            cfg_we,
	input  logic [mbce_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [mbce_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int CNT_W = (MAX_SIDE > 2) ? $clog2(MAX_SIDE) : 1;
	localparam int CMP_W = ((mbce_pkg::SIZE_W > CNT_W) ? mbce_pkg::SIZE_W : CNT_W) + 2;
	localparam int IDX_W = $clog2(mbce_pkg::PIX_PER_BYTE);
	localparam logic [CMP_W-1:0] SIDE_MAX = CMP_W'(MAX_SIDE);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(mbce_pkg::PIX_PER_BYTE - 1);

	mbce_pkg::cfg_t cfg;

	mbce_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	logic [mbce_pkg::BYTE_W-1:0]  bits_q;
	logic [IDX_W-1:0]             idx_q;
	logic                         busy_q;
	logic [CNT_W-1:0]             col_q;
	logic [CNT_W-1:0]             row_q;

	logic                         out_valid_q;
	logic [mbce_pkg::COLOR_W-1:0] out_color_q;
	logic                         out_row_end_q;
	logic                         out_frame_end_q;
	logic                         out_byte_done_q;

	logic [CMP_W-1:0] w_raw, h_raw, w_eff, h_eff;
	logic             adv, take, row_end_c, frame_end_c, last_c;

	assign w_raw = CMP_W'(cfg.area_width);
	assign h_raw = CMP_W'(cfg.area_height);

	always_comb begin
		if (w_raw == '0)
			w_eff = CMP_W'(1);
		else if (w_raw > SIDE_MAX)
			w_eff = SIDE_MAX;
		else
			w_eff = w_raw;
		if (h_raw == '0)
			h_eff = CMP_W'(1);
		else if (h_raw > SIDE_MAX)
			h_eff = SIDE_MAX;
		else
			h_eff = h_raw;
	end

	assign row_end_c   = (CMP_W'(col_q) + CMP_W'(1)) >= w_eff;
	assign frame_end_c = row_end_c && ((CMP_W'(row_q) + CMP_W'(1)) >= h_eff);
	assign last_c      = frame_end_c || (idx_q == IDX_LAST);

	assign adv          = busy_q && (!out_valid_q || pixel.ready);
	assign bitmap.ready = !busy_q || (adv && last_c);
	assign take         = bitmap.valid && bitmap.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
			col_q  <= '0;
			row_q  <= '0;
		end else begin
			if (take) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (adv) begin
				busy_q <= !last_c;
				idx_q  <= idx_q + IDX_W'(1);
			end
			if (adv) begin
				if (row_end_c) begin
					col_q <= '0;
					row_q <= frame_end_c ? '0 : row_q + CNT_W'(1);
				end else begin
					col_q <= col_q + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			bits_q <= bitmap.bitmap_byte;
		else if (adv)
			bits_q <= {bits_q[mbce_pkg::BYTE_W-2:0], 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= 1'b1;
		else if (pixel.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_color_q     <= bits_q[mbce_pkg::BYTE_W-1] ? cfg.fg_color : cfg.bg_color;
			out_row_end_q   <= row_end_c;
			out_frame_end_q <= frame_end_c;
			out_byte_done_q <= last_c;
		end
	end

	assign pixel.valid       = out_valid_q;
	assign pixel.pixel_color = out_color_q;
	assign pixel.row_end     = out_row_end_q;
	assign pixel.frame_end   = out_frame_end_q;
	assign pixel.byte_done   = out_byte_done_q;

	// frame end always closes a row and the byte
	a_frame_marks: assert property (@(posedge clk) disable iff (!arst_n)
		pixel.valid && pixel.frame_end |-> pixel.row_end && pixel.byte_done)
		else $error("frame_end without row_end/byte_done");

	// counters restart after the last pixel of the area
	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		adv && frame_end_c |=> col_q == '0 && row_q == '0)
		else $error("counters not cleared at frame end");

	// a new byte enters a busy stage only as its last pixel is produced
	a_take_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		take && busy_q |-> adv && last_c)
		else $error("byte accepted mid-expansion");

	// eighth pixel of a byte is always its last
	a_byte_len: assert property (@(posedge clk) disable iff (!arst_n)
		adv && idx_q == IDX_LAST |=> !busy_q || $past(take))
		else $error("byte expanded past eight pixels");

endmodule

// ===== rtl/mbce_cfg_regs.sv =====
// mbce_cfg_regs: write-only configuration register file (colors, area size).
// Depends on mbce_pkg.
module mbce_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [mbce_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [mbce_pkg::CFG_DATA_W-1:0]   cfg_data,
	output mbce_pkg::cfg_t                    cfg
);

	mbce_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fg_color    <= mbce_pkg::FG_RST;
			cfg_q.bg_color    <= mbce_pkg::BG_RST;
			cfg_q.area_width  <= mbce_pkg::WIDTH_RST;
			cfg_q.area_height <= mbce_pkg::HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (mbce_pkg::cfg_reg_t'(cfg_idx))
				mbce_pkg::REG_FG_COLOR:    cfg_q.fg_color    <= cfg_data;
				mbce_pkg::REG_BG_COLOR:    cfg_q.bg_color    <= cfg_data;
				mbce_pkg::REG_AREA_WIDTH:  cfg_q.area_width  <= cfg_data[mbce_pkg::SIZE_W-1:0];
				mbce_pkg::REG_AREA_HEIGHT: cfg_q.area_height <= cfg_data[mbce_pkg::SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
